// ===== sv/i2cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Types and constants of the byte level i2c master: timing segments,
// command and operation codes, the ack timeout reset and the bits per byte.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

	// one-hot timing segments
	typedef enum logic [14:0] {
		PH_IDLE     = 15'h0001,
		PH_ST_A     = 15'h0002,
		PH_ST_B     = 15'h0004,
		PH_SP_A     = 15'h0008,
		PH_SP_B     = 15'h0010,
		PH_WR_SET   = 15'h0020,
		PH_WR_HIGH  = 15'h0040,
		PH_WR_LOW   = 15'h0080,
		PH_ACK_SET  = 15'h0100,
		PH_ACK_HIGH = 15'h0200,
		PH_ACK_POLL = 15'h0400,
		PH_RD_LOW   = 15'h0800,
		PH_RD_HIGH  = 15'h1000,
		PH_MA_LOW   = 15'h2000,
		PH_MA_HIGH  = 15'h4000
	} phase_t;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_RDACK = 3'd3;
	localparam logic [2:0] CMD_RDNAK = 3'd4;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd250;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

endpackage

// ===== sv/i2c_bitbang_master_byte_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_bitbang_master_byte_engine_top
// Byte level i2c master stepped by phase ticks: start, stop, write with
// ack check, read with ack or nack, ack timeout with forced stop.
// ----------------------------------------------------------------------------
// Every accepted item (a phase tick or a command offer) gives one result in
// the cycle after acceptance, and a new item is taken in every cycle: the
// bus state is updated in a single step from the item and the state
// registers, which also serve as the result register. The input stalls only
// while a result waits and the output is stalled. A phase tick ends one bus
// timing segment; commands offered while busy, or with codes above 4, are
// ignored. A write leaves SCL high and polls SDA once per tick for the slave
// ack; more than ack_timeout high polls set ack_error and run a stop.
module i2c_bitbang_master_byte_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [2:0]  command,
	input  logic [7:0]  tx_byte,
	input  logic        sda_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_error
);
	import i2cbb_pkg::*;

	logic [15:0] ack_timeout_q;
	phase_t      phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d, bit_count_inc;
	logic [7:0]  tx_shift_q, tx_shift_d, tx_shift_nxt;
	logic [7:0]  rx_shift_q, rx_shift_d;
	logic [15:0] wait_count_q, wait_count_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        err_q, err_d;
	logic [2:0]  cur_cmd_q, cur_cmd_d;
	logic        done_q, done_d;
	logic        out_valid_q;
	logic        accept;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign bit_count_inc = bit_count_q + 4'd1;
	assign tx_shift_nxt  = {tx_shift_q[6:0], 1'b0};

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		tx_shift_d   = tx_shift_q;
		rx_shift_d   = rx_shift_q;
		wait_count_d = wait_count_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		err_d        = err_q;
		cur_cmd_d    = cur_cmd_q;
		done_d       = 1'b0;
		if (operation == OP_COMMAND) begin
			if (phase_q == PH_IDLE && command <= CMD_RDNAK) begin
				cur_cmd_d    = command;
				err_d        = 1'b0;
				bit_count_d  = '0;
				wait_count_d = '0;
				case (command)
					CMD_START: begin
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = PH_ST_A;
					end
					CMD_STOP: begin
						scl_d   = 1'b0;
						sda_d   = 1'b0;
						phase_d = PH_SP_A;
					end
					CMD_WRITE: begin
						tx_shift_d = tx_byte;
						scl_d      = 1'b0;
						sda_d      = tx_byte[7];
						phase_d    = PH_WR_SET;
					end
					default: begin
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						phase_d = PH_RD_LOW;
					end
				endcase
			end
		end else begin
			case (phase_q)
				PH_IDLE: ;
				PH_ST_A: begin
					sda_d   = 1'b0;
					phase_d = PH_ST_B;
				end
				PH_ST_B: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_SP_A: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = PH_SP_B;
				end
				PH_SP_B: begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_WR_SET: begin
					scl_d   = 1'b1;
					phase_d = PH_WR_HIGH;
				end
				PH_WR_HIGH: begin
					scl_d   = 1'b0;
					phase_d = PH_WR_LOW;
				end
				PH_WR_LOW: begin
					bit_count_d = bit_count_inc;
					tx_shift_d  = tx_shift_nxt;
					if (bit_count_inc < BITS_PER_BYTE) begin
						sda_d   = tx_shift_nxt[7];
						phase_d = PH_WR_SET;
					end else begin
						sda_d   = 1'b1;
						phase_d = PH_ACK_SET;
					end
				end
				PH_ACK_SET: begin
					scl_d   = 1'b1;
					phase_d = PH_ACK_HIGH;
				end
				PH_ACK_HIGH: begin
					wait_count_d = '0;
					phase_d      = PH_ACK_POLL;
				end
				PH_ACK_POLL: begin
					if (!sda_line) begin
						scl_d   = 1'b0;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else if (wait_count_q >= ack_timeout_q) begin
						// no ack in time: abort through a stop
						err_d   = 1'b1;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
						phase_d = PH_SP_A;
					end else begin
						wait_count_d = wait_count_q + 16'd1;
					end
				end
				PH_RD_LOW: begin
					scl_d      = 1'b1;
					rx_shift_d = {rx_shift_q[6:0], sda_line};
					phase_d    = PH_RD_HIGH;
				end
				PH_RD_HIGH: begin
					bit_count_d = bit_count_inc;
					scl_d       = 1'b0;
					if (bit_count_inc < BITS_PER_BYTE) begin
						phase_d = PH_RD_LOW;
					end else begin
						sda_d   = (cur_cmd_q == CMD_RDACK) ? 1'b0 : 1'b1;
						phase_d = PH_MA_LOW;
					end
				end
				PH_MA_LOW: begin
					scl_d   = 1'b1;
					phase_d = PH_MA_HIGH;
				end
				PH_MA_HIGH: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			ack_timeout_q <= cfg_wdata;
		end
	end

	// state registers double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			tx_shift_q   <= '0;
			rx_shift_q   <= '0;
			wait_count_q <= '0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			err_q        <= 1'b0;
			cur_cmd_q    <= CMD_START;
			done_q       <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			tx_shift_q   <= tx_shift_d;
			rx_shift_q   <= rx_shift_d;
			wait_count_q <= wait_count_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			err_q        <= err_d;
			cur_cmd_q    <= cur_cmd_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_level   = scl_q;
	assign sda_release = sda_q;
	assign busy_res    = (phase_q != PH_IDLE);
	assign done_res    = done_q;
	assign rx_byte     = rx_shift_q;
	assign ack_error   = err_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == PH_IDLE)
		else $error("done without returning to idle");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty result register");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BITS_PER_BYTE)
		else $error("bit count out of range");

	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> phase_q == PH_SP_A && !scl_q && !sda_q)
		else $error("ack error without forced stop");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item gave no result");
`endif

endmodule
